// File: sv/rfs_pkg.sv
// Shared constants, types and CRC helper for the frame deframer.
`timescale 1ns / 1ps
package rfs_pkg;

  // Frame geometry: two header bytes, then the payload bit stream
  localparam int FRAME_BYTES  = 21;
  localparam int PAYLOAD_BITS = (FRAME_BYTES - 2) * 8;
  // Payload bytes held in the shift line; the last byte comes straight from the input
  localparam int SHIFT_BITS   = PAYLOAD_BITS - 8;
  localparam int POS_W        = 5;
  localparam logic [POS_W-1:0] FIRST_POS = POS_W'(2);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CRC_END   = POS_W'(19);

  // CRC-16, reflected polynomial
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // Configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 1'b1;
  localparam logic [7:0] HDR_FIRST_RST  = 8'd169;
  localparam logic [7:0] HDR_SECOND_RST = 8'd83;

  typedef struct packed {
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
  } cfg_t;

  // Registered input byte handed to the deframer
  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } rx_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/rfs_if.sv
// Valid/ready channel interfaces for received bytes and unpacked frames.
`timescale 1ns / 1ps
interface rfs_byte_if import rfs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfs_frame_if import rfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [43:0]        sticks;
  logic [5:0]         switches;
  logic [10:0]        dial;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic signed [15:0] mouse_z;
  logic [5:0]         mouse_buttons;
  logic [15:0]        keys;
  logic [15:0]        frame_crc_field;
  logic               crc_ok;

  modport source (output valid, output sticks, output switches, output dial,
                  output mouse_x, output mouse_y, output mouse_z, output mouse_buttons,
                  output keys, output frame_crc_field, output crc_ok, input ready);
  modport sink   (input valid, input sticks, input switches, input dial,
                  input mouse_x, input mouse_y, input mouse_z, input mouse_buttons,
                  input keys, input frame_crc_field, input crc_ok, output ready);
endinterface

// File: sv/rfs_in_stage.sv
// Input register stage: captures one received byte per cycle while the deframer keeps taking them.
`timescale 1ns / 1ps
module rfs_in_stage import rfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfs_byte_if.sink   in_if,
  input  logic       take_i,
  output rx_t        rx_o
);

  logic       vld_q;
  logic [7:0] byte_q;

  // Free the stage when empty or when the deframer consumes the held item
  assign in_if.ready = !vld_q || take_i;

  // Hold valid; clear once consumed unless refilled in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_if.ready) begin
      vld_q <= in_if.valid;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      byte_q <= in_if.rx_byte;
    end
  end

  assign rx_o.vld     = vld_q;
  assign rx_o.rx_byte = byte_q;

endmodule

// File: sv/rfs_deframer.sv
// Header hunt, frame collection, CRC and unpacked result register.
`timescale 1ns / 1ps
module rfs_deframer import rfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  rx_t        rx_i,
  output logic       take_o,
  rfs_frame_if.source out_if
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_GOT1,
    PH_COLLECT
  } phase_e;

  phase_e                phase_q;
  logic [POS_W-1:0]      pos_q;
  logic [15:0]           crc_q;
  logic [SHIFT_BITS-1:0] shift_q;
  logic                  out_vld_q;

  logic                    emit;
  logic                    advance;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [15:0]             rx_crc;
  logic [7:0]              b;

  assign b = rx_i.rx_byte;

  // The last frame byte is the only one that produces an item
  assign emit    = (phase_q == PH_COLLECT) && (pos_q == LAST_POS);
  assign advance = rx_i.vld && (!emit || !out_vld_q || out_if.ready);
  assign take_o  = advance;

  // Full payload stream: stored bytes 2..19 plus the incoming byte 20
  assign pay    = {b, shift_q};
  assign rx_crc = {b, shift_q[SHIFT_BITS-1 -: 8]};

  // Advance phase, position and CRC; hold the output valid until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      pos_q     <= '0;
      crc_q     <= CRC_SEED;
      out_vld_q <= 1'b0;
    end else begin
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        case (phase_q)
          PH_GOT1: begin
            if (b == cfg_i.hdr_second) begin
              crc_q   <= crc_fold(crc_fold(CRC_SEED, cfg_i.hdr_first), b);
              pos_q   <= FIRST_POS;
              phase_q <= PH_COLLECT;
            end else if (b == cfg_i.hdr_first) begin
              phase_q <= PH_GOT1;
            end else begin
              phase_q <= PH_HUNT;
            end
          end
          PH_COLLECT: begin
            if (pos_q < CRC_END) begin
              crc_q <= crc_fold(crc_q, b);
            end
            if (emit) begin
              phase_q   <= PH_HUNT;
              pos_q     <= '0;
              crc_q     <= CRC_SEED;
            end else begin
              pos_q <= pos_q + POS_W'(1);
            end
          end
          default: begin
            phase_q <= (b == cfg_i.hdr_first) ? PH_GOT1 : PH_HUNT;
          end
        endcase
      end
    end
  end

  // Shift payload bytes in while collecting
  always_ff @(posedge clk_i) begin
    if (advance && (phase_q == PH_COLLECT) && !emit) begin
      shift_q <= {b, shift_q[SHIFT_BITS-1:8]};
    end
  end

  // Unpack the frame into the result register
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_if.sticks          <= pay[43:0];
      out_if.switches        <= {pay[60], pay[48:44]};
      out_if.dial            <= pay[59:49];
      out_if.mouse_x         <= pay[76:61];
      out_if.mouse_y         <= pay[92:77];
      out_if.mouse_z         <= pay[108:93];
      out_if.mouse_buttons   <= pay[114:109];
      out_if.keys            <= pay[130:115];
      out_if.frame_crc_field <= pay[146:131];
      out_if.crc_ok          <= (crc_q == rx_crc);
    end
  end

  assign out_if.valid = out_vld_q;

endmodule

// File: sv/remote_frame_sync_unpack.sv
// A frame's last byte passes the input register, then the result register, before its item is valid.
// Throughput: one byte per cycle; only a frame's last byte waits on a stalled item.
// Header bytes come from the configuration registers, written at any cycle.
// Reset (async, active low) clears the hunt state, CRC, valids and sets the
// header registers to 0xA9 and 0x53; frame payload storage is not reset.
`timescale 1ns / 1ps
module remote_frame_sync_unpack import rfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rfs_byte_if.sink             in_if,
  rfs_frame_if.source          out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);

  cfg_t cfg_q;
  rx_t  rx;
  logic take;

  // Write the header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_first  <= HDR_FIRST_RST;
      cfg_q.hdr_second <= HDR_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HDR_FIRST:  cfg_q.hdr_first  <= cfg_wdata_i;
        CFG_HDR_SECOND: cfg_q.hdr_second <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rfs_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .take_i (take),
    .rx_o   (rx)
  );

  rfs_deframer u_dfr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .rx_i   (rx),
    .take_o (take),
    .out_if (out_if)
  );

endmodule

// File: sv/rfs_checker.sv
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps
module rfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] keys_i,
  input logic [43:0] sticks_i
);

  // A waiting item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("item dropped while stalled");

  // A waiting item keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(keys_i) && $stable(sticks_i))
    else $error("item payload changed while stalled");

  // Input back-pressure only comes from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled result");

  // A fresh result follows an accepted byte through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching accepted byte");

endmodule

bind remote_frame_sync_unpack rfs_checker u_rfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .keys_i      (out_if.keys),
  .sticks_i    (out_if.sticks)
);

// File: dv/remote_frame_sync_unpack_test.sv
// Self-checking testbench for the header-sync frame deframer with its own deframing model.
`timescale 1ns / 1ps
module remote_frame_sync_unpack_test;
  import rfs_pkg::*;

  localparam int          FRAME_LEN = 21;
  localparam int          CRC_BYTES = 19;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  typedef enum logic [1:0] {SYNC_HUNT, SYNC_GOT_FIRST, SYNC_COLLECT} sync_e;

  typedef struct packed {
    logic [43:0]        sticks;
    logic [5:0]         switches;
    logic [10:0]        dial;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [5:0]         mouse_buttons;
    logic [15:0]        keys;
    logic [15:0]        frame_crc_field;
    logic               crc_ok;
  } frame_fields_t;

  // Deframer model plus the queue of unpacked frames still owed by the block
  class frame_scoreboard;
    logic [7:0]    hdr_first;
    logic [7:0]    hdr_second;
    sync_e         phase;
    int            pos;
    logic [7:0]    store [FRAME_LEN];
    logic [15:0]   crc;
    frame_fields_t expected_frames [$];
    int            errors;

    function new();
      hdr_first  = 8'hA9;
      hdr_second = 8'h53;
      phase      = SYNC_HUNT;
      pos        = 0;
      crc        = CRC_INIT;
      errors     = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    // Shift one byte into a reflected CRC-16, one data bit at a time
    static function logic [15:0] crc_fold_byte(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c  = c >> 1;
        if (fb) c = c ^ 16'h8408;
      end
      return c;
    endfunction

    // Advance the sync state on one accepted byte; queue a frame when one completes
    function void take_byte(logic [7:0] b);
      logic [151:0]  payload;
      frame_fields_t f;
      case (phase)
        SYNC_GOT_FIRST: begin
          if (b == hdr_second) begin
            store[0] = hdr_first;
            store[1] = b;
            crc      = crc_fold_byte(crc_fold_byte(CRC_INIT, hdr_first), b);
            pos      = 2;
            phase    = SYNC_COLLECT;
          end else if (b == hdr_first) begin
            phase = SYNC_GOT_FIRST;
          end else begin
            phase = SYNC_HUNT;
          end
        end
        SYNC_COLLECT: begin
          store[pos] = b;
          if (pos < CRC_BYTES) crc = crc_fold_byte(crc, b);
          pos++;
          if (pos == FRAME_LEN) begin
            // Payload is a little-endian bit stream starting at byte 2
            for (int k = 0; k < FRAME_LEN - 2; k++) payload[8*k +: 8] = store[2 + k];
            f.sticks          = payload[43:0];
            f.switches        = {payload[60], payload[48:44]};
            f.dial            = payload[59:49];
            f.mouse_x         = payload[76:61];
            f.mouse_y         = payload[92:77];
            f.mouse_z         = payload[108:93];
            f.mouse_buttons   = payload[114:109];
            f.keys            = payload[130:115];
            f.frame_crc_field = payload[146:131];
            f.crc_ok          = (crc == {store[20], store[19]});
            expected_frames.push_back(f);
            phase = SYNC_HUNT;
            pos   = 0;
            crc   = CRC_INIT;
          end
        end
        default: phase = (b == hdr_first) ? SYNC_GOT_FIRST : SYNC_HUNT;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) report($sformatf("%s: expected %0h, got %0h", name, want, got));
    endfunction

    // Match one accepted frame against the oldest expected one
    function void check_frame(frame_fields_t got);
      frame_fields_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("frame with none expected: %p", got));
        return;
      end
      want = expected_frames.pop_front();
      compare("sticks", 64'(want.sticks), 64'(got.sticks));
      compare("switches", 64'(want.switches), 64'(got.switches));
      compare("dial", 64'(want.dial), 64'(got.dial));
      compare("mouse_x", 64'(want.mouse_x), 64'(got.mouse_x));
      compare("mouse_y", 64'(want.mouse_y), 64'(got.mouse_y));
      compare("mouse_z", 64'(want.mouse_z), 64'(got.mouse_z));
      compare("mouse_buttons", 64'(want.mouse_buttons), 64'(got.mouse_buttons));
      compare("keys", 64'(want.keys), 64'(got.keys));
      compare("frame_crc_field", 64'(want.frame_crc_field), 64'(got.frame_crc_field));
      compare("crc_ok", 64'(want.crc_ok), 64'(got.crc_ok));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_wdata_i;

  rfs_byte_if  byte_ch ();
  rfs_frame_if frame_ch ();

  frame_scoreboard board;
  int              burst_left = 5;
  int              frame_bytes = 0;
  bit              hold_req = 1'b0;

  remote_frame_sync_unpack u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (byte_ch),
    .out_if      (frame_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Give up after a generous bound
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one byte at the falling edge, hold it until taken, then maybe pause the burst
  task automatic send_byte(input logic [7:0] b);
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk_i);
    while (byte_ch.ready !== 1'b1) @(posedge clk_i);
    board.take_byte(b);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 20);
    end
  endtask

  // Send a whole frame with the current header; content style picked by mode
  task automatic send_frame(input int mode, input bit good_crc);
    logic [7:0]  fr [FRAME_LEN];
    logic [15:0] c;
    fr[0] = board.hdr_first;
    fr[1] = board.hdr_second;
    for (int i = 2; i < FRAME_LEN; i++) begin
      case (mode)
        1: fr[i] = 8'h00;
        2: fr[i] = 8'hFF;
        3: fr[i] = ($urandom_range(0, 2) == 0) ? board.hdr_first :
                   ($urandom_range(0, 1) == 0) ? board.hdr_second : 8'($urandom);
        default: fr[i] = 8'($urandom);
      endcase
    end
    c = CRC_INIT;
    for (int i = 0; i < CRC_BYTES; i++) c = frame_scoreboard::crc_fold_byte(c, fr[i]);
    fr[19] = c[7:0];
    fr[20] = c[15:8];
    if (!good_crc) begin
      if ($urandom_range(0, 1) == 0) fr[19] = fr[19] ^ 8'(1 << $urandom_range(0, 7));
      else                          fr[20] = fr[20] ^ 8'(1 << $urandom_range(0, 7));
    end
    foreach (fr[i]) send_byte(fr[i]);
    frame_bytes += FRAME_LEN;
  endtask

  // Random bytes, biased toward the header values
  task automatic send_noise(input int n);
    int         r;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 7);
      b = (r < 2) ? board.hdr_first : (r == 2) ? board.hdr_second : 8'($urandom);
      send_byte(b);
    end
  endtask

  // Write both header registers; the block is idle here
  task automatic set_headers(input logic [7:0] f, input logic [7:0] s);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HDR_FIRST;
    cfg_wdata_i <= f;
    @(negedge clk_i);
    board.hdr_first = f;
    cfg_idx_i   <= CFG_HDR_SECOND;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    board.hdr_second = s;
    cfg_we_i    <= 1'b0;
  endtask

  // Drop valid, drain all owed frames, then allow for the output pipeline
  task automatic wait_idle();
    byte_ch.valid <= 1'b0;
    while (board.expected_frames.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Receiver: ready patterns that change over time, plus one long hold-off
  initial begin
    int   mode;
    int   left;
    int   cnt;
    logic rdy;
    frame_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    cnt  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        frame_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        cnt++;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (cnt % 5) != 0;
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        frame_ch.ready <= rdy;
      end
    end
  end

  // Check every frame taken by the receiver
  always @(posedge clk_i) begin : mon
    frame_fields_t got;
    if (rst_ni && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
      got.sticks          = frame_ch.sticks;
      got.switches        = frame_ch.switches;
      got.dial            = frame_ch.dial;
      got.mouse_x         = frame_ch.mouse_x;
      got.mouse_y         = frame_ch.mouse_y;
      got.mouse_z         = frame_ch.mouse_z;
      got.mouse_buttons   = frame_ch.mouse_buttons;
      got.keys            = frame_ch.keys;
      got.frame_crc_field = frame_ch.frame_crc_field;
      got.crc_ok          = frame_ch.crc_ok;
      board.check_frame(got);
    end
  end

  initial begin
    logic [7:0]  seq [$];
    logic [7:0]  hdr_set [8][2];
    logic [15:0] c;
    logic [7:0]  b;
    int          start;
    int          pick;
    int          sel;
    int          mode;

    board           = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_HDR_FIRST;
    cfg_wdata_i     = 8'h00;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_headers(8'hA9, 8'h53);

    // Directed: noise, a broken header, a repeated first byte, then a frame whose
    // content starts with a header pair (no resync) and is otherwise all ones
    seq = '{8'h00, 8'hFF, 8'hA9, 8'h00, 8'hA9, 8'hA9, 8'h53, 8'hA9, 8'h53};
    repeat (15) seq.push_back(8'hFF);
    c = CRC_INIT;
    for (int i = 5; i < seq.size(); i++) c = frame_scoreboard::crc_fold_byte(c, seq[i]);
    seq.push_back(c[7:0]);
    seq.push_back(c[15:8]);
    foreach (seq[i]) send_byte(seq[i]);

    // Header settings per phase: reset values, extremes, equal pairs, random
    hdr_set = '{'{8'hA9, 8'h53}, '{8'h00, 8'hFF}, '{8'hFF, 8'h00}, '{8'h7E, 8'h7E},
                '{8'h00, 8'h00}, '{8'hFF, 8'hFF}, '{8'h00, 8'h00}, '{8'h00, 8'h00}};
    for (int p = 0; p < 8; p++) begin
      if (p >= 6) begin
        hdr_set[p][0] = 8'($urandom);
        hdr_set[p][1] = 8'($urandom);
      end
      wait_idle();
      set_headers(hdr_set[p][0], hdr_set[p][1]);
      // Stall the receiver for a long stretch while frames keep coming
      if (p == 1) hold_req = 1'b1;
      start = frame_bytes;
      while (frame_bytes - start < 145) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          if (pick == 0) begin
            // Broken header ahead of the frame
            send_byte(board.hdr_first);
            b = 8'($urandom);
            while (b == board.hdr_second) b = 8'($urandom);
            send_byte(b);
          end
          sel  = $urandom_range(0, 9);
          mode = (sel < 6) ? 0 : (sel < 7) ? 1 : (sel < 8) ? 2 : 3;
          send_frame(mode, $urandom_range(0, 3) != 0);
        end else begin
          send_noise($urandom_range(1, 6));
        end
      end
    end

    wait_idle();
    if (board.errors == 0 && board.expected_frames.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
